@@ rtl/pretrigger_capture_average_trigger_assert.svh @@
// assertion macros for the pretrigger capture block
`ifndef PRETRIGGER_CAPTURE_AVERAGE_TRIGGER_ASSERT_SVH
`define PRETRIGGER_CAPTURE_AVERAGE_TRIGGER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define PCAT_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define PCAT_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/pcat_pkg.sv @@
// shared types and constants for the pretrigger capture block
package pcat_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int RATIO_W     = 10;
    localparam int PRETRIG_W   = 10;
    localparam int READ_W      = 10;
    localparam int AVG_W       = 16;
    localparam int RV_W        = 17;
    localparam int FUNC_W      = 2;
    localparam int CFG_ADDR_W  = 1;
    localparam int CFG_DATA_W  = 10;
    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 40;

    localparam logic [RATIO_W-1:0]   RATIO_RESET   = 10'd384;
    localparam logic [PRETRIG_W-1:0] PRETRIG_RESET = 10'd200;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_SAMPLE  = 2'd0,
        FUNC_READ    = 2'd1,
        FUNC_RELEASE = 2'd2
    } func_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_TRIG_RATIO = 1'b0,
        REG_PRETRIG    = 1'b1
    } reg_idx_t;

    typedef logic [AVG_W-1:0] avg_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    // first member lands in the highest bits
    typedef struct packed {
        logic [AVG_W-1:0]       window_average;
        logic signed [RV_W-1:0] read_value;
        logic                   sample_dropped;
        logic                   capture_done;
    } res_t;

    localparam int RES_W = $bits(res_t);

endpackage

@@ rtl/pcat_ring_ram.sv @@
// sample ring memory, one write port and one registered read port
module pcat_ring_ram #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10,
    parameter int DATA_W = 12
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/pcat_divider.sv @@
// iterative restoring divider for the held average, one quotient bit a cycle
module pcat_divider #(
    parameter int NUM_W = 26,
    parameter int DEN_W = 11
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [NUM_W-1:0]      num,
    input  logic [DEN_W-1:0]      den,
    output pcat_pkg::avg_t        quotient,
    output pcat_pkg::div_status_t status
);
    import pcat_pkg::*;

    localparam int CNT_W = $clog2(AVG_W + 1);

    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [AVG_W-1:0] quo_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DEN_W:0]   shifted;
    logic             qbit;
    logic [DEN_W-1:0] rem_next;

    // quotient fits AVG_W bits, so the upper part of num is already below den
    always_comb begin
        shifted  = {rem_reg, quo_reg[AVG_W-1]};
        qbit     = (shifted >= (DEN_W+1)'(den_reg));
        rem_next = qbit ? DEN_W'(shifted - (DEN_W+1)'(den_reg)) : DEN_W'(shifted);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                rem_reg  <= DEN_W'(num >> AVG_W);
                quo_reg  <= num[AVG_W-1:0];
                den_reg  <= den;
                cnt_reg  <= CNT_W'(AVG_W);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rem_reg <= rem_next;
                quo_reg <= {quo_reg[AVG_W-2:0], qbit};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quotient = quo_reg;
    assign status   = '{busy: busy_reg, done: done_reg};

endmodule

@@ rtl/pretrigger_capture_average_trigger.sv @@
// top level: moving-average trigger with pretriggered window capture
//
//  channel   | group   | transaction carries
//  ----------+---------+------------------------------------------------------
//  input     | s_axis_ | func in tuser; sample_value, read_index in tdata
//  result    | m_axis_ | capture_done, sample_dropped, read_value, window_average
//  config    | cfg_    | register index and write data, no handshake
//
//  a sample steps through ring read of the evicted entry, sum update and
//  write, product registers, compare, result push
//  a capturing sample also waits on the bit-serial average divider
//  a read steps through index reduction (two steps), address add, ring read
//  release, unused codes and dropped samples go straight to the result push;
//  one transaction is in work at a time
//  reset clears the control state at once; ring entries at or past the fill
//  count read as zero, so the ring needs no clearing pass
//  a stalled result sits in the output register while the next item is taken
module pretrigger_capture_average_trigger #(
    parameter int WINDOW = 1024
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input channel
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [pcat_pkg::S_TDATA_W-1:0]      s_axis_tdata,  // sample_value, read_index
    input  logic [pcat_pkg::FUNC_W-1:0]         s_axis_tuser,  // func
    // result channel
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // capture_done, sample_dropped, read_value, window_average
    output logic [pcat_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    // configuration writes
    input  logic                                cfg_wr_en,
    input  logic [pcat_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [pcat_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import pcat_pkg::*;

    localparam int PW    = $clog2(WINDOW);
    localparam int FW    = $clog2(WINDOW + 1);
    localparam int SUM_W = SAMPLE_BITS + PW;
    localparam int LHS_W = SAMPLE_BITS + FW;
    localparam int RHS_W = SUM_W + RATIO_W;
    localparam int CMP_W = RHS_W + 1;
    // read index reduction: floor(r / WINDOW) by reciprocal, then one correction
    localparam int RECIP_K   = READ_W + PW + 1;
    localparam int RECIP_M_W = READ_W + 2;
    localparam int RECIP_M   = (1 << RECIP_K) / WINDOW;
    localparam int PROD_W    = READ_W + RECIP_M_W;
    localparam int QP_W      = READ_W + PW + 1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EVICT,
        ST_MUL,
        ST_CMP,
        ST_DIV,
        ST_RQUO,
        ST_RREM,
        ST_RADDR,
        ST_RDATA,
        ST_PUSH
    } state_t;

    state_t state_reg;

    // configuration registers
    logic [RATIO_W-1:0]   cfg_ratio_reg;
    logic [PRETRIG_W-1:0] cfg_pretrig_reg;

    // block state
    logic [PW-1:0]    wp_reg;
    logic [SUM_W-1:0] sum_reg;
    logic [FW-1:0]    fill_reg;
    logic             armed_reg;
    logic [PW-1:0]    end_ptr_reg;
    logic             hold_reg;
    logic [PW-1:0]    ws_reg;
    avg_t             held_avg_reg;

    // per-item working registers
    logic [SAMPLE_BITS-1:0] sample_reg;
    logic [READ_W-1:0]      read_idx_reg;
    logic [PW-1:0]          t_reg;
    logic [LHS_W-1:0]       lhs_reg;
    logic [RHS_W-1:0]       rhs_reg;
    logic [PW-1:0]          cand_end_reg;
    logic [READ_W-1:0]      quo_reg;
    logic [PW-1:0]          rem_reg;
    logic [PW-1:0]          pos_reg;
    res_t                   res_reg;
    res_t                   m_data_reg;
    logic                   m_valid_reg;

    // ring port
    logic                   ram_we;
    logic                   ram_re;
    logic [PW-1:0]          ram_raddr;
    logic [SAMPLE_BITS-1:0] ram_rdata;

    // divider
    logic                div_start;
    avg_t                div_quo;
    div_status_t         div_status;

    // datapath
    logic                   accept;
    logic                   push;
    func_t                  in_func;
    logic                   full;
    logic [SAMPLE_BITS-1:0] evict_val;
    logic [SUM_W-1:0]       sum_upd;
    logic [PW-1:0]          wp_inc;
    logic [PW-1:0]          p_eff;
    logic [PW:0]            end_full;
    logic [PW-1:0]          end_cand;
    logic [CMP_W-1:0]       lhs_cmp;
    logic [CMP_W-1:0]       rhs_cmp;
    logic                   fire;
    logic                   armed_now;
    logic [PW-1:0]          end_now;
    logic                   freeze;
    logic [PROD_W-1:0]      recip_prod;
    logic [QP_W-1:0]        rem_full;
    logic [PW-1:0]          rem_mod;
    logic [PW:0]            pos_full;
    logic [PW-1:0]          pos_mod;
    logic [SAMPLE_BITS-1:0] rd_word;
    logic [RV_W-1:0]        rd_value;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid & s_axis_tready;
    assign in_func       = func_t'(s_axis_tuser);
    // output register free or draining this cycle
    assign push          = (state_reg == ST_PUSH) && (!m_valid_reg || m_axis_tready);

    always_comb begin
        full      = (fill_reg == FW'(WINDOW));
        // once the ring is full, the entry under the write pointer leaves the sum
        evict_val = full ? ram_rdata : '0;
        sum_upd   = sum_reg - SUM_W'(evict_val) + SUM_W'(sample_reg);
        wp_inc    = (wp_reg == PW'(WINDOW - 1)) ? '0 : wp_reg + 1'b1;

        // pretrigger length clamped to one less than the ring
        if (32'(cfg_pretrig_reg) > WINDOW - 1) begin
            p_eff = PW'(WINDOW - 1);
        end else begin
            p_eff = PW'(cfg_pretrig_reg);
        end
        end_full = (PW+1)'(t_reg) + (PW+1)'(WINDOW) - (PW+1)'(p_eff);
        end_cand = (end_full >= (PW+1)'(WINDOW)) ? PW'(end_full - (PW+1)'(WINDOW))
                                                 : PW'(end_full);

        // sample * count * 256 against sum * ratio
        lhs_cmp   = CMP_W'({lhs_reg, 8'b0});
        rhs_cmp   = CMP_W'(rhs_reg);
        fire      = !armed_reg && (lhs_cmp > rhs_cmp);
        armed_now = armed_reg || fire;
        end_now   = fire ? cand_end_reg : end_ptr_reg;
        freeze    = armed_now && (wp_reg == end_now);

        // read index modulo the ring length
        recip_prod = PROD_W'(read_idx_reg) * PROD_W'(RECIP_M);
        rem_full   = QP_W'(read_idx_reg) - QP_W'(quo_reg) * QP_W'(WINDOW);
        rem_mod    = (rem_full >= QP_W'(WINDOW)) ? PW'(rem_full - QP_W'(WINDOW))
                                                 : PW'(rem_full);
        pos_full   = (PW+1)'(ws_reg) + (PW+1)'(rem_reg);
        pos_mod    = (pos_full >= (PW+1)'(WINDOW)) ? PW'(pos_full - (PW+1)'(WINDOW))
                                                   : PW'(pos_full);

        // entries not yet written since reset read as zero
        rd_word  = (full || (FW'(pos_reg) < fill_reg)) ? ram_rdata : '0;
        rd_value = RV_W'({rd_word, 4'b0}) - RV_W'(held_avg_reg);
    end

    // ring port: eviction read on sample accept, window read in the address step
    always_comb begin
        ram_re    = (state_reg == ST_IDLE) || (state_reg == ST_RADDR);
        ram_raddr = (state_reg == ST_RADDR) ? pos_mod : wp_reg;
        ram_we    = (state_reg == ST_EVICT);
        div_start = (state_reg == ST_CMP) && freeze;
    end

    pcat_ring_ram #(
        .DEPTH  (WINDOW),
        .ADDR_W (PW),
        .DATA_W (SAMPLE_BITS)
    ) u_ring (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (wp_reg),
        .wdata (sample_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    pcat_divider #(
        .NUM_W (SUM_W + 4),
        .DEN_W (FW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .num      ({sum_reg, 4'b0}),
        .den      (fill_reg),
        .quotient (div_quo),
        .status   (div_status)
    );

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_ratio_reg   <= RATIO_RESET;
            cfg_pretrig_reg <= PRETRIG_RESET;
        end else if (cfg_wr_en) begin
            unique case (reg_idx_t'(cfg_addr))
                REG_TRIG_RATIO: cfg_ratio_reg   <= cfg_wdata[RATIO_W-1:0];
                REG_PRETRIG:    cfg_pretrig_reg <= cfg_wdata[PRETRIG_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer, block state and result registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            wp_reg       <= '0;
            sum_reg      <= '0;
            fill_reg     <= '0;
            armed_reg    <= 1'b0;
            end_ptr_reg  <= '0;
            hold_reg     <= 1'b0;
            ws_reg       <= '0;
            held_avg_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (push) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        sample_reg   <= s_axis_tdata[SAMPLE_BITS-1:0];
                        read_idx_reg <= s_axis_tdata[SAMPLE_BITS +: READ_W];
                        res_reg      <= '{window_average: held_avg_reg, read_value: '0,
                                          sample_dropped: (in_func == FUNC_SAMPLE) && hold_reg,
                                          capture_done: 1'b0};
                        case (in_func)
                            FUNC_SAMPLE: begin
                                if (hold_reg) begin
                                    state_reg <= ST_PUSH;
                                end else begin
                                    state_reg <= ST_EVICT;
                                end
                            end
                            FUNC_READ: begin
                                state_reg <= ST_RQUO;
                            end
                            FUNC_RELEASE: begin
                                hold_reg  <= 1'b0;
                                state_reg <= ST_PUSH;
                            end
                            default: begin
                                state_reg <= ST_PUSH;
                            end
                        endcase
                    end
                end
                ST_EVICT: begin
                    // ring data of the old entry is here; write the new sample
                    sum_reg   <= sum_upd;
                    fill_reg  <= full ? fill_reg : fill_reg + 1'b1;
                    t_reg     <= wp_reg;
                    wp_reg    <= wp_inc;
                    state_reg <= ST_MUL;
                end
                ST_MUL: begin
                    lhs_reg      <= LHS_W'(sample_reg) * LHS_W'(fill_reg);
                    rhs_reg      <= RHS_W'(sum_reg) * RHS_W'(cfg_ratio_reg);
                    cand_end_reg <= end_cand;
                    state_reg    <= ST_CMP;
                end
                ST_CMP: begin
                    end_ptr_reg <= end_now;
                    if (freeze) begin
                        // window frozen: oldest entry sits under the write pointer
                        armed_reg <= 1'b0;
                        hold_reg  <= 1'b1;
                        ws_reg    <= wp_reg;
                        state_reg <= ST_DIV;
                    end else begin
                        armed_reg <= armed_now;
                        state_reg <= ST_PUSH;
                    end
                end
                ST_DIV: begin
                    if (div_status.done) begin
                        held_avg_reg <= div_quo;
                        res_reg      <= '{window_average: div_quo, read_value: '0,
                                          sample_dropped: 1'b0, capture_done: 1'b1};
                        state_reg    <= ST_PUSH;
                    end
                end
                ST_RQUO: begin
                    quo_reg   <= READ_W'(recip_prod >> RECIP_K);
                    state_reg <= ST_RREM;
                end
                ST_RREM: begin
                    rem_reg   <= rem_mod;
                    state_reg <= ST_RADDR;
                end
                ST_RADDR: begin
                    pos_reg   <= pos_mod;
                    state_reg <= ST_RDATA;
                end
                ST_RDATA: begin
                    res_reg.read_value <= rd_value;
                    state_reg          <= ST_PUSH;
                end
                ST_PUSH: begin
                    if (push) begin
                        m_data_reg <= res_reg;
                        state_reg  <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{(M_TDATA_W - RES_W){1'b0}}, m_data_reg};

    `include "pretrigger_capture_average_trigger_assert.svh"

    // a held window and a pending trigger never coexist
    `PCAT_ASSERT_IMPL(a_hold_not_armed, aclk, aresetn, hold_reg, !armed_reg, "armed while holding")
    // the divider is started only when idle
    `PCAT_ASSERT_IMPL(a_div_idle, aclk, aresetn, div_start, !div_status.busy, "divider restarted")
    // a capture always waits on the divider next
    `PCAT_ASSERT_NEXT(a_div_wait, aclk, aresetn, div_start, state_reg == ST_DIV, "no divider wait")
    // one transaction in work at a time
    `PCAT_ASSERT_NEXT(a_one_item, aclk, aresetn, accept, !s_axis_tready, "second item taken")

endmodule
